// ===== rtl/core/ess_pkg.sv =====
// shared types, constants and helpers of the exact substring search block
// no dependencies; used by the result and csr interfaces and every module of the block
package ess_pkg;

   localparam int unsigned PATTERN_W = 64;
   localparam int unsigned LENGTH_W  = 4;
   localparam int unsigned START_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [7:0]  CASE_GAP  = 8'd32;
   localparam logic [7:0]  UPPER_A   = 8'h41;
   localparam logic [7:0]  UPPER_Z   = 8'h5A;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_BYTES  = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_CASE_SENSITIVE = 2'd2,
      REG_ENTIRE_STRING  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern_bytes;
      logic [LENGTH_W-1:0]  pattern_length;
      logic                 case_sensitive;
      logic                 entire_string;
   } cfg_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
      logic       empty_text;
   } item_type;

   typedef struct packed {
      logic                found;
      logic [START_W-1:0]  match_start;
      logic [LENGTH_W-1:0] match_length;
   } result_type;

   // fold A-Z to lower case when folding is enabled
   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
      if (fold_en && (c inside {[UPPER_A:UPPER_Z]})) begin
         return c + CASE_GAP;
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/ess_channels.sv =====
// valid/ready channel interfaces: text words in, result words out, csr writes
// depends on ess_pkg for field widths
interface ess_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       last_char;
   logic       empty_text;
   modport source(output valid, text_char, last_char, empty_text, input ready);
   modport sink(input valid, text_char, last_char, empty_text, output ready);
endinterface

interface ess_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [ess_pkg::START_W-1:0]  match_start;
   logic [ess_pkg::LENGTH_W-1:0] match_length;
   modport source(output valid, found, match_start, match_length, input ready);
   modport sink(input valid, found, match_start, match_length, output ready);
endinterface

interface ess_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ess_pkg::CSR_IDX_W-1:0] index;
   logic [ess_pkg::PATTERN_W-1:0] wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// ===== rtl/core/ess_match.sv =====
// parallel compare of the pattern against the newest window bytes
// depends on ess_pkg (fold_char, widths)
module ess_match #(
   parameter int unsigned MAX_PATTERN = 8
) (
   input  logic [MAX_PATTERN-1:0][7:0]    window,
   input  logic [ess_pkg::PATTERN_W-1:0]  pattern_bytes,
   input  logic [ess_pkg::LENGTH_W-1:0]   len,
   input  logic                           fold_en,
   output logic                           hit
);

   logic [MAX_PATTERN-1:0][7:0] pat_f;
   logic [MAX_PATTERN-1:0][7:0] win_f;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pat_f[k] = ess_pkg::fold_char(pattern_bytes[8*k +: 8], fold_en);
         win_f[k] = ess_pkg::fold_char(window[k], fold_en);
      end
   end

   // pattern position k lines up with the byte that came len-1-k words ago
   always_comb begin
      logic ok;
      hit = 1'b0;
      for (int l = 1; l <= MAX_PATTERN; l++) begin
         ok = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (pat_f[k] != win_f[l-1-k]) begin
               ok = 1'b0;
            end
         end
         if (len == ess_pkg::LENGTH_W'(l)) begin
            hit = ok;
         end
      end
   end

endmodule

// ===== rtl/core/ess_scan.sv =====
// per-string scan state: byte window, position count, first occurrence
// depends on ess_pkg and ess_match
module ess_scan #(
   parameter int unsigned MAX_PATTERN = 8,
   parameter int unsigned MAX_TEXT    = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ess_pkg::item_type   item,
   input  ess_pkg::cfg_type    cfg,
   output logic                close,
   output ess_pkg::result_type result
);

   localparam int unsigned CW = $clog2(MAX_TEXT + 1);
   localparam int unsigned SW = (CW > ess_pkg::START_W) ? CW : ess_pkg::START_W + 1;

   logic [MAX_PATTERN-1:0][7:0]    window_ff, window_in, shifted, win_n;
   logic [CW-1:0]                  count_ff, count_in, count_inc, count_n;
   logic                           hit_ff, hit_in;
   logic [ess_pkg::START_W-1:0]    start_ff, start_in;
   logic [ess_pkg::LENGTH_W-1:0]   len;
   logic [SW-1:0]                  start_w;
   logic                           unsat, record, match;

   always_comb begin
      len = (cfg.pattern_length > ess_pkg::LENGTH_W'(MAX_PATTERN)) ?
            ess_pkg::LENGTH_W'(MAX_PATTERN) : cfg.pattern_length;
      shifted[0] = item.text_char;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         shifted[k] = window_ff[k-1];
      end
      win_n = item.empty_text ? window_ff : shifted;
   end

   ess_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
      .window        (win_n),
      .pattern_bytes (cfg.pattern_bytes),
      .len           (len),
      .fold_en       (!cfg.case_sensitive),
      .hit           (match)
   );

   always_comb begin
      unsat     = count_ff < CW'(MAX_TEXT);
      count_inc = count_ff + CW'(1);
      count_n   = (!item.empty_text && unsat) ? count_inc : count_ff;
      start_w   = SW'(count_inc) - SW'(len);
      record    = !item.empty_text && !hit_ff && unsat && (len != '0) &&
                  (count_inc >= CW'(len)) &&
                  (start_w <= SW'({ess_pkg::START_W{1'b1}})) && match;
      close     = item.empty_text || item.last_char;

      result.match_length = len;
      result.match_start  = '0;
      if (len == '0) begin
         result.found = cfg.entire_string ? (count_n == '0) : 1'b1;
      end else if (cfg.entire_string) begin
         result.found = (count_n == CW'(len)) && match;
      end else begin
         result.found = hit_ff || record;
         if (hit_ff) begin
            result.match_start = start_ff;
         end else if (record) begin
            result.match_start = start_w[ess_pkg::START_W-1:0];
         end
      end
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      hit_in    = hit_ff;
      start_in  = start_ff;
      if (step) begin
         if (close) begin
            window_in = '0;
            count_in  = '0;
            hit_in    = 1'b0;
            start_in  = '0;
         end else begin
            window_in = shifted;
            count_in  = count_n;
            if (record) begin
               hit_in   = 1'b1;
               start_in = start_w[ess_pkg::START_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         hit_ff    <= 1'b0;
         start_ff  <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         hit_ff    <= hit_in;
         start_ff  <= start_in;
      end
   end

endmodule

// ===== rtl/core/exact_substring_search.sv =====
// exact_substring_search: streaming first-occurrence substring matcher
// a result word leaves after its closing text word passes the input register,
//   then the result register; throughput one text word per cycle while the result
//   channel does not stall, with the window compare combinational between the two registers
// reset (synchronous, active high) clears the scan state, the pipeline valids
//   and the csr registers (case_sensitive resets to 1, the rest to 0)
module exact_substring_search #(
   parameter int unsigned MAX_PATTERN = 8,
   parameter int unsigned MAX_TEXT    = 65536
) (
   input logic       clock,
   input logic       reset,
   ess_req_if.sink   req_chan,
   ess_rsp_if.source rsp_chan,
   ess_csr_if.sink   csr_chan
);

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   ess_pkg::item_type   s1_item_ff, s1_item_in;
   // result stage
   logic                rsp_valid_ff, rsp_valid_in;
   ess_pkg::result_type rsp_data_ff, rsp_data_in;
   // csr registers
   ess_pkg::cfg_type    cfg_ff, cfg_in;

   logic                advance;
   logic                step;
   logic                close;
   ess_pkg::result_type result;

   // the whole pipe moves when the result register is free or being drained
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign step    = s1_valid_ff && advance;

   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   // capture the incoming word
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_chan.ready) begin
         s1_valid_in          = req_chan.valid;
         s1_item_in.text_char  = req_chan.text_char;
         s1_item_in.last_char  = req_chan.last_char;
         s1_item_in.empty_text = req_chan.empty_text;
      end
   end

   // scan state and match decision for the registered word
   ess_scan #(.MAX_PATTERN(MAX_PATTERN), .MAX_TEXT(MAX_TEXT)) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .close  (close),
      .result (result)
   );

   // only a closing word produces a result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff && close;
         rsp_data_in  = result;
      end
   end

   // csr write decode, narrow registers keep their low bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (ess_pkg::csr_index_type'(csr_chan.index))
            ess_pkg::REG_PATTERN_BYTES: begin
               cfg_in.pattern_bytes = csr_chan.wdata;
            end
            ess_pkg::REG_PATTERN_LENGTH: begin
               cfg_in.pattern_length = csr_chan.wdata[ess_pkg::LENGTH_W-1:0];
            end
            ess_pkg::REG_CASE_SENSITIVE: begin
               cfg_in.case_sensitive = csr_chan.wdata[0];
            end
            ess_pkg::REG_ENTIRE_STRING: begin
               cfg_in.entire_string = csr_chan.wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.pattern_bytes  <= '0;
         cfg_ff.pattern_length <= '0;
         cfg_ff.case_sensitive <= 1'b1;
         cfg_ff.entire_string  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_data_ff.found;
   assign rsp_chan.match_start  = rsp_data_ff.match_start;
   assign rsp_chan.match_length = rsp_data_ff.match_length;

`ifndef SYNTHESIS
   // a new result word only follows a word held in the input stage
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result word without a source word");

   // no position reported when nothing was found
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.match_start == '0))
      else $error("match_start set without a match");

   // reported length is clamped to the window depth
   a_len_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.match_length <= ess_pkg::LENGTH_W'(MAX_PATTERN)))
      else $error("match_length above window depth");

   // an accepted word is always held in the input stage next cycle
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted word dropped");
`endif

endmodule
